[design/ple_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    // Default width of a number token's value.
    localparam int VALUE_BITS_DEFAULT = 31;

    // Token groups waiting between the front and back ends (a power of two).
    localparam int QUEUE_DEPTH = 4;

    // One character produces at most this many tokens.
    localparam int GROUP_MAX = 3;

    // Token codes as they appear on the result port.
    typedef enum logic [4:0] {
        KIND_NUMBER  = 5'd0,
        KIND_VAR     = 5'd1,
        KIND_MUL     = 5'd2,
        KIND_DIV     = 5'd3,
        KIND_MOD     = 5'd4,
        KIND_ADD     = 5'd5,
        KIND_SUB     = 5'd6,
        KIND_OPEN    = 5'd7,
        KIND_CLOSE   = 5'd8,
        KIND_COND    = 5'd9,
        KIND_ALT     = 5'd10,
        KIND_NOT     = 5'd11,
        KIND_NE      = 5'd12,
        KIND_LT      = 5'd13,
        KIND_LE      = 5'd14,
        KIND_GT      = 5'd15,
        KIND_GE      = 5'd16,
        KIND_LAND    = 5'd17,
        KIND_LOR     = 5'd18,
        KIND_EQ      = 5'd19,
        KIND_UNKNOWN = 5'd20,
        KIND_END     = 5'd21
    } token_kind_t;

    // What the lexer is holding on to between characters.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BANG = 3'd1,
        MODE_LT   = 3'd2,
        MODE_GT   = 3'd3,
        MODE_AMP  = 3'd4,
        MODE_PIPE = 3'd5,
        MODE_EQ   = 3'd6,
        MODE_NUM  = 3'd7
    } lex_mode_t;

    // The tokens caused by one character, oldest in slot zero.
    typedef struct packed {
        logic [1:0]                    count;
        token_kind_t [GROUP_MAX-1:0]   kinds;
    } token_group_t;

    // Character codes.
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_PCT    = 8'h25;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_QUEST  = 8'h3F;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_PIPE   = 8'h7C;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;

endpackage

`default_nettype wire

[design/ple_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_front #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             character,
    input  wire logic                   final_char,
    input  wire logic                   grp_full,
    output logic                        grp_push,
    output ple_pkg::token_group_t       grp,
    output logic [VALUE_BITS-1:0]       grp_value
);

    localparam int WIDE_BITS = VALUE_BITS + 4;

    ple_pkg::lex_mode_t     mode_reg;
    ple_pkg::lex_mode_t     mode_next;
    logic [VALUE_BITS-1:0]  acc_reg;
    logic [VALUE_BITS-1:0]  acc_next;
    logic                   accept;
    logic                   is_digit;
    logic [WIDE_BITS-1:0]   acc_wide;

    // A character is taken whenever the group queue has room.
    assign full   = grp_full;
    assign accept = push && !grp_full;

    assign is_digit = (character >= ple_pkg::CHAR_0) && (character <= ple_pkg::CHAR_9);

    // Next decimal step, acc * 10 + digit, with room to detect overflow.
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {{(WIDE_BITS-4){1'b0}}, character[3:0]};

    // Resolve the pending operator, classify the character, close the expression if final.
    always_comb
    begin
        logic        consumed;
        logic [1:0]  count;
        int          i;

        consumed  = 1'b0;
        count     = 2'd0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        grp_value = '0;
        for (i = 0; i < ple_pkg::GROUP_MAX; i++)
        begin
            grp.kinds[i] = ple_pkg::KIND_UNKNOWN;
        end

        // Finish whatever the previous character left open.
        case (mode_reg)
            ple_pkg::MODE_BANG, ple_pkg::MODE_LT, ple_pkg::MODE_GT:
            begin
                if (character == ple_pkg::CHAR_EQ)
                begin
                    consumed = 1'b1;
                    case (mode_reg)
                        ple_pkg::MODE_BANG: grp.kinds[count] = ple_pkg::KIND_NE;
                        ple_pkg::MODE_LT:   grp.kinds[count] = ple_pkg::KIND_LE;
                        default:            grp.kinds[count] = ple_pkg::KIND_GE;
                    endcase
                end
                else
                begin
                    case (mode_reg)
                        ple_pkg::MODE_BANG: grp.kinds[count] = ple_pkg::KIND_NOT;
                        ple_pkg::MODE_LT:   grp.kinds[count] = ple_pkg::KIND_LT;
                        default:            grp.kinds[count] = ple_pkg::KIND_GT;
                    endcase
                end
                count     = count + 2'd1;
                mode_next = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_AMP:
            begin
                grp.kinds[count] = (character == ple_pkg::CHAR_AMP) ?
                                   ple_pkg::KIND_LAND : ple_pkg::KIND_UNKNOWN;
                count     = count + 2'd1;
                consumed  = 1'b1;
                mode_next = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_PIPE:
            begin
                grp.kinds[count] = (character == ple_pkg::CHAR_PIPE) ?
                                   ple_pkg::KIND_LOR : ple_pkg::KIND_UNKNOWN;
                count     = count + 2'd1;
                consumed  = 1'b1;
                mode_next = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_EQ:
            begin
                grp.kinds[count] = (character == ple_pkg::CHAR_EQ) ?
                                   ple_pkg::KIND_EQ : ple_pkg::KIND_UNKNOWN;
                count     = count + 2'd1;
                consumed  = 1'b1;
                mode_next = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_NUM:
            begin
                if (is_digit)
                begin
                    consumed = 1'b1;
                    if (acc_wide[WIDE_BITS-1:VALUE_BITS] != 4'd0)
                    begin
                        acc_next = '1;
                    end
                    else
                    begin
                        acc_next = acc_wide[VALUE_BITS-1:0];
                    end
                end
                else
                begin
                    grp.kinds[count] = ple_pkg::KIND_NUMBER;
                    grp_value        = acc_reg;
                    count            = count + 2'd1;
                    mode_next        = ple_pkg::MODE_IDLE;
                    acc_next         = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Classify the character when nothing above used it.
        if (!consumed)
        begin
            if (is_digit)
            begin
                mode_next = ple_pkg::MODE_NUM;
                acc_next  = {{(VALUE_BITS-4){1'b0}}, character[3:0]};
            end
            else
            begin
                case (character)
                    ple_pkg::CHAR_N:      grp.kinds[count] = ple_pkg::KIND_VAR;
                    ple_pkg::CHAR_STAR:   grp.kinds[count] = ple_pkg::KIND_MUL;
                    ple_pkg::CHAR_SLASH:  grp.kinds[count] = ple_pkg::KIND_DIV;
                    ple_pkg::CHAR_PCT:    grp.kinds[count] = ple_pkg::KIND_MOD;
                    ple_pkg::CHAR_PLUS:   grp.kinds[count] = ple_pkg::KIND_ADD;
                    ple_pkg::CHAR_MINUS:  grp.kinds[count] = ple_pkg::KIND_SUB;
                    ple_pkg::CHAR_LPAREN: grp.kinds[count] = ple_pkg::KIND_OPEN;
                    ple_pkg::CHAR_RPAREN: grp.kinds[count] = ple_pkg::KIND_CLOSE;
                    ple_pkg::CHAR_QUEST:  grp.kinds[count] = ple_pkg::KIND_COND;
                    ple_pkg::CHAR_COLON:  grp.kinds[count] = ple_pkg::KIND_ALT;
                    default:              grp.kinds[count] = ple_pkg::KIND_UNKNOWN;
                endcase
                case (character)
                    ple_pkg::CHAR_BANG:  mode_next = ple_pkg::MODE_BANG;
                    ple_pkg::CHAR_LT:    mode_next = ple_pkg::MODE_LT;
                    ple_pkg::CHAR_GT:    mode_next = ple_pkg::MODE_GT;
                    ple_pkg::CHAR_AMP:   mode_next = ple_pkg::MODE_AMP;
                    ple_pkg::CHAR_PIPE:  mode_next = ple_pkg::MODE_PIPE;
                    ple_pkg::CHAR_EQ:    mode_next = ple_pkg::MODE_EQ;
                    ple_pkg::CHAR_SPACE, ple_pkg::CHAR_TAB, ple_pkg::CHAR_LF:
                    begin
                    end
                    default:             count = count + 2'd1;
                endcase
            end
        end

        // On the last character, flush anything pending and close with an end token.
        if (final_char)
        begin
            case (mode_next)
                ple_pkg::MODE_BANG:
                begin
                    grp.kinds[count] = ple_pkg::KIND_NOT;
                    count            = count + 2'd1;
                end
                ple_pkg::MODE_LT:
                begin
                    grp.kinds[count] = ple_pkg::KIND_LT;
                    count            = count + 2'd1;
                end
                ple_pkg::MODE_GT:
                begin
                    grp.kinds[count] = ple_pkg::KIND_GT;
                    count            = count + 2'd1;
                end
                ple_pkg::MODE_AMP, ple_pkg::MODE_PIPE, ple_pkg::MODE_EQ:
                begin
                    grp.kinds[count] = ple_pkg::KIND_UNKNOWN;
                    count            = count + 2'd1;
                end
                ple_pkg::MODE_NUM:
                begin
                    grp.kinds[count] = ple_pkg::KIND_NUMBER;
                    grp_value        = acc_next;
                    count            = count + 2'd1;
                end
                default:
                begin
                end
            endcase
            grp.kinds[count] = ple_pkg::KIND_END;
            count            = count + 2'd1;
            mode_next        = ple_pkg::MODE_IDLE;
            acc_next         = '0;
        end

        grp.count = count;
        grp_push  = accept && (count != 2'd0);
    end

    // Lexer state advances on every accepted character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ple_pkg::MODE_IDLE;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

[design/ple_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_queue #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire ple_pkg::token_group_t       wr_group,
    input  wire logic [VALUE_BITS-1:0]       wr_value,
    output logic                             q_full,
    input  wire logic                        rd_en,
    output ple_pkg::token_group_t            rd_group,
    output logic [VALUE_BITS-1:0]            rd_value,
    output logic                             q_empty
);

    localparam int PTR_BITS = $clog2(ple_pkg::QUEUE_DEPTH);

    ple_pkg::token_group_t  group_mem_reg [ple_pkg::QUEUE_DEPTH];
    logic [VALUE_BITS-1:0]  value_mem_reg [ple_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [PTR_BITS:0]      count_reg;
    logic [PTR_BITS:0]      count_next;
    logic                   do_wr;
    logic                   do_rd;

    // Status comes straight from the occupancy register.
    assign q_full  = (count_reg == (PTR_BITS+1)'(ple_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    assign rd_group = group_mem_reg[rd_ptr_reg];
    assign rd_value = value_mem_reg[rd_ptr_reg];

    // Occupancy follows writes and reads in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Group storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            group_mem_reg[wr_ptr_reg] <= wr_group;
            value_mem_reg[wr_ptr_reg] <= wr_value;
        end
    end

endmodule

`default_nettype wire

[design/ple_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_back #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ple_pkg::token_group_t       head_group,
    input  wire logic [VALUE_BITS-1:0]       head_value,
    input  wire logic                        q_empty,
    output logic                             q_rd,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [4:0]                       token_kind,
    output logic [VALUE_BITS-1:0]            number_value,
    output logic                             last_token
);

    logic [1:0]            idx_reg;
    logic [1:0]            idx_next;
    ple_pkg::token_kind_t  cur_kind;
    logic                  transfer;
    logic                  group_done;

    // The current token is slot idx of the oldest group.
    assign cur_kind     = head_group.kinds[idx_reg];
    assign empty        = q_empty;
    assign token_kind   = cur_kind;
    assign number_value = (cur_kind == ple_pkg::KIND_NUMBER) ? head_value : '0;
    assign last_token   = (cur_kind == ple_pkg::KIND_END);

    // Retire the group once its final token has been transferred.
    assign transfer   = pop && !q_empty;
    assign group_done = (idx_reg == head_group.count - 2'd1);
    assign q_rd       = transfer && group_done;

    always_comb
    begin
        idx_next = idx_reg;
        if (transfer)
        begin
            idx_next = group_done ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

[design/plural_expression_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer for C-like plural-form expressions. One character is taken per
// clock cycle while full is low; each character yields zero to three tokens (a pending
// operator or number, the character's own token, and the end token on the last
// character), which come out one per cycle in order while pop is held high, so the
// sustained input rate is one character per cycle unless the consumer drains tokens more
// slowly than they are made. The lexer front end settles a character's whole token group
// in the cycle it is accepted and writes it into a four-entry group queue; the back end
// hands out the tokens of the oldest group one transfer at a time. A result shows up on
// the outputs once its group is at the head of the queue. Number values saturate at
// 2^VALUE_BITS - 1, and number_value reads zero on every other token.
module plural_expression_lexer #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             character,
    input  wire logic                   final_char,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [4:0]                  token_kind,
    output logic [VALUE_BITS-1:0]       number_value,
    output logic                        last_token
);

    ple_pkg::token_group_t  wr_group;
    logic [VALUE_BITS-1:0]  wr_value;
    logic                   wr_en;
    logic                   q_full;
    ple_pkg::token_group_t  head_group;
    logic [VALUE_BITS-1:0]  head_value;
    logic                   q_empty;
    logic                   q_rd;

    // Front end: classification and lexer state.
    ple_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .character  (character),
        .final_char (final_char),
        .grp_full   (q_full),
        .grp_push   (wr_en),
        .grp        (wr_group),
        .grp_value  (wr_value)
    );

    // Token groups between the two ends.
    ple_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_group (wr_group),
        .wr_value (wr_value),
        .q_full   (q_full),
        .rd_en    (q_rd),
        .rd_group (head_group),
        .rd_value (head_value),
        .q_empty  (q_empty)
    );

    // Back end: one token per transfer.
    ple_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_group   (head_group),
        .head_value   (head_value),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .number_value (number_value),
        .last_token   (last_token)
    );

endmodule

`default_nettype wire

[design/ple_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_checker #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEFAULT
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [4:0]             token_kind,
    input wire logic [VALUE_BITS-1:0]  number_value,
    input wire logic                   last_token
);

    // The end mark travels only with the end token, and always with it.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_token == (token_kind == ple_pkg::KIND_END)))
        else $error("last_token does not match the end token");

    // Only number tokens carry a value.
    a_value_only_on_number: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (number_value != '0)) |-> (token_kind == ple_pkg::KIND_NUMBER))
        else $error("nonzero value on a token that is not a number");

    // A waiting token is held until it is transferred.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(number_value)
                              && $stable(last_token)))
        else $error("waiting token changed before its transfer");

endmodule

bind plural_expression_lexer ple_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_ple_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .token_kind   (token_kind),
    .number_value (number_value),
    .last_token   (last_token)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_W = ple_pkg::VALUE_BITS_DEFAULT;
    localparam logic [VALUE_W-1:0] VALUE_SAT = {VALUE_W{1'b1}};
    localparam int HOLD_CYCLES = 64;
    localparam int RANDOM_CHARS = 230;

    // One token as it should appear on the result ports.
    typedef struct {
        ple_pkg::token_kind_t kind;
        logic [VALUE_W-1:0]   value;
        bit                   last;
    } token_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         character = 8'h00;
    logic               final_char = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [4:0]         token_kind;
    logic [VALUE_W-1:0] number_value;
    logic               last_token;

    // Predicted lexer state.
    ple_pkg::lex_mode_t pend_mode = ple_pkg::MODE_IDLE;
    logic [VALUE_W-1:0] num_acc = '0;

    token_rec_t         expected_tokens[$];
    logic [7:0]         expr_bytes[$];
    int                 error_count = 0;
    int                 pop_wait = 0;
    bit                 calm = 1'b0;
    logic               hold_active = 1'b0;
    event               hold_go;

    plural_expression_lexer #(
        .VALUE_BITS(VALUE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .character(character),
        .final_char(final_char),
        .empty(empty),
        .pop(pop),
        .token_kind(token_kind),
        .number_value(number_value),
        .last_token(last_token)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Random idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic add_token(input ple_pkg::token_kind_t kind,
                             input logic [VALUE_W-1:0] value, input bit last);
        token_rec_t t;
        t.kind = kind;
        t.value = value;
        t.last = last;
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    // Emit whatever is pending as if no more characters followed.
    task automatic flush_pending();
        case (pend_mode)
            ple_pkg::MODE_BANG: add_token(ple_pkg::KIND_NOT, '0, 1'b0);
            ple_pkg::MODE_LT:   add_token(ple_pkg::KIND_LT, '0, 1'b0);
            ple_pkg::MODE_GT:   add_token(ple_pkg::KIND_GT, '0, 1'b0);
            ple_pkg::MODE_AMP, ple_pkg::MODE_PIPE, ple_pkg::MODE_EQ:
                add_token(ple_pkg::KIND_UNKNOWN, '0, 1'b0);
            ple_pkg::MODE_NUM:  add_token(ple_pkg::KIND_NUMBER, num_acc, 1'b0);
            default: ;
        endcase
        pend_mode = ple_pkg::MODE_IDLE;
        num_acc = '0;
    endtask

    // A character seen with nothing pending.
    task automatic take_idle(input logic [7:0] c);
        if (c >= ple_pkg::CHAR_0 && c <= ple_pkg::CHAR_9)
        begin
            pend_mode = ple_pkg::MODE_NUM;
            num_acc = VALUE_W'(c - ple_pkg::CHAR_0);
        end
        else
        begin
            case (c)
                ple_pkg::CHAR_N:      add_token(ple_pkg::KIND_VAR, '0, 1'b0);
                ple_pkg::CHAR_STAR:   add_token(ple_pkg::KIND_MUL, '0, 1'b0);
                ple_pkg::CHAR_SLASH:  add_token(ple_pkg::KIND_DIV, '0, 1'b0);
                ple_pkg::CHAR_PCT:    add_token(ple_pkg::KIND_MOD, '0, 1'b0);
                ple_pkg::CHAR_PLUS:   add_token(ple_pkg::KIND_ADD, '0, 1'b0);
                ple_pkg::CHAR_MINUS:  add_token(ple_pkg::KIND_SUB, '0, 1'b0);
                ple_pkg::CHAR_LPAREN: add_token(ple_pkg::KIND_OPEN, '0, 1'b0);
                ple_pkg::CHAR_RPAREN: add_token(ple_pkg::KIND_CLOSE, '0, 1'b0);
                ple_pkg::CHAR_QUEST:  add_token(ple_pkg::KIND_COND, '0, 1'b0);
                ple_pkg::CHAR_COLON:  add_token(ple_pkg::KIND_ALT, '0, 1'b0);
                ple_pkg::CHAR_BANG:   pend_mode = ple_pkg::MODE_BANG;
                ple_pkg::CHAR_LT:     pend_mode = ple_pkg::MODE_LT;
                ple_pkg::CHAR_GT:     pend_mode = ple_pkg::MODE_GT;
                ple_pkg::CHAR_AMP:    pend_mode = ple_pkg::MODE_AMP;
                ple_pkg::CHAR_PIPE:   pend_mode = ple_pkg::MODE_PIPE;
                ple_pkg::CHAR_EQ:     pend_mode = ple_pkg::MODE_EQ;
                ple_pkg::CHAR_SPACE, ple_pkg::CHAR_TAB, ple_pkg::CHAR_LF: ;
                default:              add_token(ple_pkg::KIND_UNKNOWN, '0, 1'b0);
            endcase
        end
    endtask

    // Work out the tokens that one accepted character causes.
    task automatic predict_tokens(input logic [7:0] c, input bit fin);
        longint unsigned digit;
        longint unsigned acc_wide;
        case (pend_mode)
            ple_pkg::MODE_BANG, ple_pkg::MODE_LT, ple_pkg::MODE_GT:
            begin
                if (c == ple_pkg::CHAR_EQ)
                begin
                    if (pend_mode == ple_pkg::MODE_BANG)
                        add_token(ple_pkg::KIND_NE, '0, 1'b0);
                    else if (pend_mode == ple_pkg::MODE_LT)
                        add_token(ple_pkg::KIND_LE, '0, 1'b0);
                    else
                        add_token(ple_pkg::KIND_GE, '0, 1'b0);
                    pend_mode = ple_pkg::MODE_IDLE;
                end
                else
                begin
                    flush_pending();
                    take_idle(c);
                end
            end
            // Doubled operators consume the next character whatever it is.
            ple_pkg::MODE_AMP:
            begin
                add_token((c == ple_pkg::CHAR_AMP) ? ple_pkg::KIND_LAND
                                                   : ple_pkg::KIND_UNKNOWN, '0, 1'b0);
                pend_mode = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_PIPE:
            begin
                add_token((c == ple_pkg::CHAR_PIPE) ? ple_pkg::KIND_LOR
                                                    : ple_pkg::KIND_UNKNOWN, '0, 1'b0);
                pend_mode = ple_pkg::MODE_IDLE;
            end
            ple_pkg::MODE_EQ:
            begin
                add_token((c == ple_pkg::CHAR_EQ) ? ple_pkg::KIND_EQ
                                                  : ple_pkg::KIND_UNKNOWN, '0, 1'b0);
                pend_mode = ple_pkg::MODE_IDLE;
            end
            // Digits accumulate and stick at the saturation value.
            ple_pkg::MODE_NUM:
            begin
                if (c >= ple_pkg::CHAR_0 && c <= ple_pkg::CHAR_9)
                begin
                    digit = c - ple_pkg::CHAR_0;
                    acc_wide = num_acc;
                    if (acc_wide > (longint'(VALUE_SAT) - digit) / 10)
                        num_acc = VALUE_SAT;
                    else
                        num_acc = VALUE_W'(acc_wide * 10 + digit);
                end
                else
                begin
                    flush_pending();
                    take_idle(c);
                end
            end
            default:
                take_idle(c);
        endcase
        if (fin)
        begin
            flush_pending();
            add_token(ple_pkg::KIND_END, '0, 1'b1);
        end
    endtask

    // Offer one character after a random gap and wait for its transfer.
    task automatic send_char(input logic [7:0] c, input bit fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        character <= c;
        final_char <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tokens(c, fin);
    endtask

    task automatic send_text(input string s, input bit fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], fin_at_end && (i == s.len() - 1));
    endtask

    task automatic append_byte(input logic [7:0] b);
        expr_bytes.insert(expr_bytes.size(), b);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    // The plain single-character tokens and every two-character operator.
    task automatic test_operator_tokens();
        send_text("n*/%+-()?:", 1'b0);
        send_text("!=<=>=&&||==", 1'b1);
    endtask

    // Flushes, undoubled and trailing operators, odd bytes and overflow.
    task automatic test_special_cases();
        // A lone bang, a lone less-than, and a zero byte on the last character.
        send_text("!<", 1'b0);
        send_char(8'h00, 1'b1);
        // An undoubled ampersand swallows the next byte.
        send_text("&", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text(" \t\n", 1'b0);
        send_char(8'h0D, 1'b0);
        // A trailing pipe becomes an unknown token.
        send_text("|", 1'b1);
        send_text(">", 1'b1);
        // Ten nines overflow the value width.
        send_text("09999999999", 1'b1);
    endtask

    // The consumer holds off while characters keep coming, so the block fills.
    task automatic test_full_stall();
        -> hold_go;
        calm = 1'b1;
        send_text("n*n/n%n+n-n?n:n(n)n*n/n!n<n>n", 1'b1);
        calm = 1'b0;
    endtask

    // Random expressions built mostly from well-formed pieces.
    task automatic test_random_expressions();
        string simple_chars;
        string pairs;
        string singles;
        int sent;
        int pieces;
        int r;
        int idx;
        int run;
        simple_chars = "n*/%+-()?:";
        pairs = "!=<=>=&&||==";
        singles = "!<>&|=";
        sent = 0;
        while (sent < RANDOM_CHARS)
        begin
            expr_bytes.delete();
            pieces = $urandom_range(1, 8);
            for (int p = 0; p < pieces; p++)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    append_byte(simple_chars[$urandom_range(0, 9)]);
                else if (r < 50)
                begin
                    run = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 13)
                                                       : $urandom_range(1, 3);
                    for (int d = 0; d < run; d++)
                        append_byte(ple_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
                end
                else if (r < 65)
                begin
                    idx = 2 * $urandom_range(0, 5);
                    append_text(pairs.substr(idx, idx + 1));
                end
                else if (r < 75)
                    append_byte(singles[$urandom_range(0, 5)]);
                else if (r < 85)
                begin
                    case ($urandom_range(0, 2))
                        0: append_byte(ple_pkg::CHAR_SPACE);
                        1: append_byte(ple_pkg::CHAR_TAB);
                        default: append_byte(ple_pkg::CHAR_LF);
                    endcase
                end
                else
                    append_byte(8'($urandom_range(0, 255)));
            end
            // Now and then a whole expression goes through without idling.
            calm = ($urandom_range(0, 7) == 0);
            foreach (expr_bytes[k])
                send_char(expr_bytes[k], k == expr_bytes.size() - 1);
            calm = 1'b0;
            sent += expr_bytes.size();
        end
    endtask

    // Long consumer stall, counted here.
    always
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Consumer: check each token transfer and drive pop with random stalls.
    always @(posedge clk)
    begin
        token_rec_t exp_tok;
        if (rst_n && pop && !empty)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token kind %0d value %0d last %0b", $time,
                         token_kind, number_value, last_token);
                error_count++;
            end
            else
            begin
                exp_tok = expected_tokens.pop_front();
                if (token_kind !== exp_tok.kind)
                begin
                    $display("%0t: token_kind expected %0d, got %0d", $time,
                             exp_tok.kind, token_kind);
                    error_count++;
                end
                if (number_value !== exp_tok.value)
                begin
                    $display("%0t: number_value expected %0d, got %0d", $time,
                             exp_tok.value, number_value);
                    error_count++;
                end
                if (last_token !== exp_tok.last)
                begin
                    $display("%0t: last_token expected %0b, got %0b", $time,
                             exp_tok.last, last_token);
                    error_count++;
                end
            end
        end
        if (!rst_n || hold_active)
            pop <= 1'b0;
        else if (pop_wait > 0)
        begin
            pop_wait--;
            pop <= 1'b0;
        end
        else
        begin
            pop_wait = pick_gap();
            if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operator_tokens();
        test_special_cases();
        test_full_stall();
        test_random_expressions();
        push <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("PASS plural_expression_lexer");
        else
            $display("FAIL plural_expression_lexer");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("FAIL plural_expression_lexer");
        $finish;
    end

endmodule

[files.f]
design/ple_pkg.sv
design/ple_front.sv
design/ple_queue.sv
design/ple_back.sv
design/plural_expression_lexer.sv
design/ple_checker.sv
tb/sv/testbench.sv
